>>> design/sfc_pkg.sv
package sfc_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] REG_END_CODE       = 2'd0;
  localparam logic [1:0] REG_ESCAPE_CODE    = 2'd1;
  localparam logic [1:0] REG_ESC_END_CODE   = 2'd2;
  localparam logic [1:0] REG_ESC_ESC_CODE   = 2'd3;

  localparam logic [7:0] END_CODE_RST     = 8'hC0;
  localparam logic [7:0] ESCAPE_CODE_RST  = 8'hDB;
  localparam logic [7:0] ESC_END_CODE_RST = 8'hDC;
  localparam logic [7:0] ESC_ESC_CODE_RST = 8'hDD;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW     = 3;

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } stuffed_t;

  typedef struct packed {
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] esc_end_code;
    logic [7:0] esc_esc_code;
  } codes_t;

  // delimiter match wins over escape match when both codes are equal
  function automatic stuffed_t stuff(input logic [7:0] b, input codes_t c);
    stuffed_t s;
    if (b == c.end_code) begin
      s = '{two: 1'b1, b0: c.escape_code, b1: c.esc_end_code};
    end else if (b == c.escape_code) begin
      s = '{two: 1'b1, b0: c.escape_code, b1: c.esc_esc_code};
    end else begin
      s = '{two: 1'b0, b0: b, b1: b};
    end
    return s;
  endfunction

endpackage

>>> design/slip_framer_with_checksum.sv
// SLIP frame builder with a 16-bit additive checksum. Words on the slave
// stream are commands: start (sends the delimiter, clears the sum), data
// (adds the byte to the sum, sends it with delimiter/escape bytes replaced
// by two-byte escape sequences) and end (sends the two's complement of the
// sum low byte first, escaped, then the delimiter); opcode 3 is dropped.
// Each command is expanded in one pass into a 5-byte output buffer that
// drains one byte per cycle while m_axis_tready is high on the master
// stream, tlast on the command's final byte. A command yields 1 byte for
// start or plain data, 2 for escaped data, 3 to 5 for end, 0 for a dropped
// opcode; the next is taken as the last byte leaves or the buffer is empty.
// The four codes are APB registers at byte addresses 0, 4, 8 and 12; the
// user must write them only while the stream is idle; nothing enforces it.
module slip_framer_with_checksum
  import sfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] opcode, [9:2] data_byte, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  codes_t          codes_q;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      buf_q [MaxBytes];
  logic [7:0]      buf_d [MaxBytes];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] new_cnt;
  logic [7:0]      new_bytes [MaxBytes];
  logic [1:0]      opcode;
  logic [7:0]      data_byte;
  logic [15:0]     check;
  stuffed_t        st_data, st_lo, st_hi;
  logic            in_fire, out_fire, cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '{end_code: END_CODE_RST, escape_code: ESCAPE_CODE_RST,
                   esc_end_code: ESC_END_CODE_RST, esc_esc_code: ESC_ESC_CODE_RST};
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_END_CODE:     codes_q.end_code     <= pwdata[7:0];
        REG_ESCAPE_CODE:  codes_q.escape_code  <= pwdata[7:0];
        REG_ESC_END_CODE: codes_q.esc_end_code <= pwdata[7:0];
        REG_ESC_ESC_CODE: codes_q.esc_esc_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_END_CODE:     prdata = {24'd0, codes_q.end_code};
      REG_ESCAPE_CODE:  prdata = {24'd0, codes_q.escape_code};
      REG_ESC_END_CODE: prdata = {24'd0, codes_q.esc_end_code};
      REG_ESC_ESC_CODE: prdata = {24'd0, codes_q.esc_esc_code};
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = (cnt_q == CntW'(1));
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  // take a new command once the buffer is empty or its last byte is leaving
  assign s_axis_tready = (cnt_q == '0) || (m_axis_tlast && m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------- expansion ----------------
  assign opcode    = s_axis_tdata[1:0];
  assign data_byte = s_axis_tdata[9:2];
  assign check     = (~sum_q) + 16'd1;
  assign st_data   = stuff(data_byte, codes_q);
  assign st_lo     = stuff(check[7:0], codes_q);
  assign st_hi     = stuff(check[15:8], codes_q);

  always_comb begin
    for (int i = 0; i < MaxBytes; i++) begin
      new_bytes[i] = codes_q.end_code;
    end
    new_cnt = '0;
    sum_d   = sum_q;
    case (opcode)
      OP_START: begin
        new_cnt = CntW'(1);
        sum_d   = '0;
      end
      OP_DATA: begin
        new_bytes[0] = st_data.b0;
        new_bytes[1] = st_data.b1;
        new_cnt      = CntW'(1) + {{(CntW-1){1'b0}}, st_data.two};
        sum_d        = sum_q + {8'd0, data_byte};
      end
      OP_END: begin
        new_bytes[0] = st_lo.b0;
        if (st_lo.two) begin
          new_bytes[1] = st_lo.b1;
          new_bytes[2] = st_hi.b0;
          new_bytes[3] = st_hi.two ? st_hi.b1 : codes_q.end_code;
        end else begin
          new_bytes[1] = st_hi.b0;
          new_bytes[2] = st_hi.two ? st_hi.b1 : codes_q.end_code;
        end
        new_cnt = CntW'(3) + {{(CntW-1){1'b0}}, st_lo.two}
                           + {{(CntW-1){1'b0}}, st_hi.two};
      end
      default: ;
    endcase
  end

  // ---------------- output buffer ----------------
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxBytes; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (in_fire) begin
      cnt_d = new_cnt;
      for (int i = 0; i < MaxBytes; i++) begin
        buf_d[i] = new_bytes[i];
      end
    end else if (out_fire) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxBytes - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxBytes; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("output buffer count out of range");

  a_accept_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && m_axis_tvalid) |-> (m_axis_tlast && m_axis_tready))
    else $error("command taken while earlier bytes still pending");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode == OP_START) |=> (sum_q == '0 && m_axis_tvalid && m_axis_tlast))
    else $error("start command did not clear sum or emit one byte");

  a_end_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && opcode == OP_END) |=> (cnt_q >= CntW'(3)))
    else $error("end command produced too few bytes");
`endif

endmodule
